[rtl/core/cmrf_pkg.sv]
package cmrf_pkg;

    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 32;
    localparam int BYTES_W = 4;

    // widest word index the store can ever need (4096 words)
    localparam int STORE_IDX_W = 12;

    localparam logic [BYTES_W-1:0] WORD_BYTES = 4'd4;

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    // device reset control word and its warm/cold request bits
    localparam logic [ADDR_W-1:0] RSTCTRL_ADDR = 13'h0F00;
    localparam logic [1:0]        RST_REQ_MASK = 2'b11;

    // idle-status field synthesized into bits 17:16 of clock-control reads
    localparam logic [1:0] IDLE_FUNCTIONAL = 2'b00;
    localparam logic [1:0] IDLE_DISABLED   = 2'b11;

    // pll mode codes that mean the pll is bypassed
    localparam logic [2:0] PLL_MODE_MN_BYPASS = 3'd4;
    localparam logic [2:0] PLL_MODE_LP_BYPASS = 3'd5;

    localparam logic [DATA_W-1:0] PLL_STATUS_BYPASSED = 32'h0000_0100;
    localparam logic [DATA_W-1:0] PLL_STATUS_LOCKED   = 32'h0000_0001;

    localparam logic [DATA_W-1:0] DIVIDER_SEED = 32'h0000_0001;
    localparam logic [DATA_W-1:0] RATIO_SEED   = 32'((1000 << 8) | 23);

    localparam int CLKCTRL_N = 71;
    localparam logic [ADDR_W-1:0] CLKCTRL_ADDRS [CLKCTRL_N] = '{
        13'h014, 13'h018, 13'h01C, 13'h020, 13'h024, 13'h028, 13'h02C, 13'h030,
        13'h034, 13'h038, 13'h03C, 13'h040, 13'h044, 13'h048, 13'h04C, 13'h050,
        13'h060, 13'h068, 13'h06C, 13'h070, 13'h074, 13'h078, 13'h07C, 13'h080,
        13'h084, 13'h088, 13'h0AC, 13'h0B0, 13'h0B4, 13'h0B8, 13'h0BC, 13'h0C0,
        13'h0C4, 13'h0C8, 13'h0CC, 13'h0D4, 13'h0D8, 13'h0DC, 13'h0E0, 13'h0E4,
        13'h0E8, 13'h0EC, 13'h0F0, 13'h0F4, 13'h0F8, 13'h0FC, 13'h100, 13'h10C,
        13'h110, 13'h120, 13'h130, 13'h14C,
        13'h404, 13'h408, 13'h40C, 13'h410, 13'h414, 13'h4B0, 13'h4B4, 13'h4B8,
        13'h4BC, 13'h4C0, 13'h4C4, 13'h4C8, 13'h4D4,
        13'h604,
        13'h800,
        13'h904, 13'h910, 13'h914,
        13'hA20
    };

    localparam int PLL_N = 5;
    localparam logic [ADDR_W-1:0] PLL_STATUS_ADDRS [PLL_N] = '{
        13'h420, 13'h434, 13'h448, 13'h45C, 13'h470
    };
    localparam logic [ADDR_W-1:0] PLL_MODE_ADDRS [PLL_N] = '{
        13'h488, 13'h494, 13'h498, 13'h490, 13'h48C
    };

    localparam int DIVIDER_N = 7;
    localparam logic [ADDR_W-1:0] DIVIDER_ADDRS [DIVIDER_N] = '{
        13'h480, 13'h484, 13'h4D8, 13'h4A0, 13'h4A4, 13'h4A8, 13'h4AC
    };

    localparam int RATIO_N = 5;
    localparam logic [ADDR_W-1:0] RATIO_ADDRS [RATIO_N] = '{
        13'h42C, 13'h468, 13'h440, 13'h454, 13'h49C
    };

    // write and read request strobes toward the store
    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } store_cmd_t;

    function automatic logic is_clkctrl(input logic [ADDR_W-1:0] addr);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < CLKCTRL_N; i++)
        begin
            hit = hit | (addr == CLKCTRL_ADDRS[i]);
        end
        return hit;
    endfunction

    // reset value of one store word, by word index
    function automatic logic [DATA_W-1:0] seed_word(input logic [STORE_IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        val = '0;
        for (int i = 0; i < DIVIDER_N; i++)
        begin
            if (idx == {1'b0, DIVIDER_ADDRS[i][ADDR_W-1:2]})
            begin
                val = DIVIDER_SEED;
            end
        end
        for (int i = 0; i < RATIO_N; i++)
        begin
            if (idx == {1'b0, RATIO_ADDRS[i][ADDR_W-1:2]})
            begin
                val = RATIO_SEED;
            end
        end
        return val;
    endfunction

endpackage

[rtl/core/clock_module_register_file_top.sv]
// Clock-module register file: one 32-bit bus access per input transfer, one result per access.
// An access enters on s_axis, passes stage 1 and the output register, and its result leaves
// on m_axis. A new access is taken every cycle while results are drained and the store is not
// clearing, so the rate is one access per cycle, set by the single read/write port of the word
// store, which serves at most one access per cycle. Only 4-byte accesses act on the store;
// other sizes flag size_error and return 0. Clock-control offsets read back with a synthesized
// idle field in bits 17:16, the five pll status offsets answer from the paired pll mode word,
// and a write to the reset control word with bit 0 or 1 set raises reset_request. After reset
// the store clears every word, seeding divider and ratio words, while s_axis_tready stays low.
module clock_module_register_file_top #(
    parameter int REG_WORDS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [12:0] byte_address, [44:13] write_data, [48:45] access_bytes, [55:49] zero
    input  logic [55:0] s_axis_tdata,
    // [0] opcode
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data
    output logic [31:0] m_axis_tdata,
    // [0] reset_request, [1] size_error
    output logic [1:0]  m_axis_tuser
);

    localparam int IDX_W  = $clog2(REG_WORDS);
    localparam int ADDR_W = cmrf_pkg::ADDR_W;
    localparam int DATA_W = cmrf_pkg::DATA_W;

    // input field unpacking
    logic [ADDR_W-1:0]            in_addr;
    logic [DATA_W-1:0]            in_wdata;
    logic [cmrf_pkg::BYTES_W-1:0] in_bytes;
    cmrf_pkg::opcode_t            in_op;

    assign in_addr  = s_axis_tdata[12:0];
    assign in_wdata = s_axis_tdata[44:13];
    assign in_bytes = s_axis_tdata[48:45];
    assign in_op    = cmrf_pkg::opcode_t'(s_axis_tuser[0]);

    logic accept;
    logic size_ok;
    logic pll_hit;
    logic [ADDR_W-1:0] pll_mode_addr;
    logic [ADDR_W-1:0] eff_addr;
    logic [ADDR_W-1:0] widx_ext;
    logic [ADDR_W-1:0] widx_wrap;
    logic [IDX_W-1:0]  store_idx;
    logic              rst_hit;
    cmrf_pkg::store_cmd_t cmd;
    logic [DATA_W-1:0] store_rdata;
    logic              store_busy;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign size_ok = (in_bytes == cmrf_pkg::WORD_BYTES);

    // pll status reads fetch the paired mode word instead
    always_comb
    begin
        pll_hit       = 1'b0;
        pll_mode_addr = '0;
        for (int i = 0; i < cmrf_pkg::PLL_N; i++)
        begin
            if (in_addr == cmrf_pkg::PLL_STATUS_ADDRS[i])
            begin
                pll_hit       = 1'b1;
                pll_mode_addr = cmrf_pkg::PLL_MODE_ADDRS[i];
            end
        end
    end

    assign eff_addr = (in_op == cmrf_pkg::OP_READ && pll_hit) ? pll_mode_addr : in_addr;

    // word index wraps modulo REG_WORDS; the byte window never reaches twice the depth
    assign widx_ext  = {2'b00, eff_addr[ADDR_W-1:2]};
    assign widx_wrap = (widx_ext >= ADDR_W'(REG_WORDS)) ? widx_ext - ADDR_W'(REG_WORDS)
                                                         : widx_ext;
    assign store_idx = widx_wrap[IDX_W-1:0];

    assign cmd.wr_en = accept && size_ok && (in_op == cmrf_pkg::OP_WRITE);
    assign cmd.rd_en = accept && size_ok && (in_op == cmrf_pkg::OP_READ);

    assign rst_hit = (in_addr == cmrf_pkg::RSTCTRL_ADDR)
                  && ((in_wdata[1:0] & cmrf_pkg::RST_REQ_MASK) != 2'b00);

    cmrf_store #(
        .REG_WORDS (REG_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .idx     (store_idx),
        .wr_data (in_wdata),
        .rd_data (store_rdata),
        .busy    (store_busy)
    );

    // stage 1: access decoded, store word being read
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    cmrf_pkg::opcode_t s1_op_reg;
    logic              s1_serr_reg;
    logic              s1_rst_reg;
    logic              s1_pll_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_rst_reg;
    logic              out_serr_reg;

    logic              advance;
    logic [DATA_W-1:0] result;
    logic [1:0]        idle_field;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !store_busy && (!s1_valid_reg || advance);

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    // result formation from the stored word
    assign idle_field = (store_rdata[1:0] != 2'b00) ? cmrf_pkg::IDLE_FUNCTIONAL
                                                    : cmrf_pkg::IDLE_DISABLED;

    always_comb
    begin
        if (s1_serr_reg || s1_op_reg == cmrf_pkg::OP_WRITE)
        begin
            result = '0;
        end
        else if (cmrf_pkg::is_clkctrl(s1_addr_reg))
        begin
            result = {store_rdata[31:18], idle_field, store_rdata[15:0]};
        end
        else if (s1_pll_reg)
        begin
            result = (store_rdata[2:0] inside {cmrf_pkg::PLL_MODE_MN_BYPASS,
                                                cmrf_pkg::PLL_MODE_LP_BYPASS})
                   ? cmrf_pkg::PLL_STATUS_BYPASSED : cmrf_pkg::PLL_STATUS_LOCKED;
        end
        else
        begin
            result = store_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= in_addr;
            s1_op_reg   <= in_op;
            s1_serr_reg <= !size_ok;
            s1_rst_reg  <= size_ok && (in_op == cmrf_pkg::OP_WRITE) && rst_hit;
            s1_pll_reg  <= pll_hit;
        end
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= result;
            out_rst_reg  <= s1_rst_reg;
            out_serr_reg <= s1_serr_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_serr_reg, out_rst_reg};

    // no transfer taken while the clearing pass owns the store
    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n)
        store_busy |-> !s_axis_tready
    ) else $error("input transfer possible during clearing pass");

    // a full stage 1 behind a stalled output must block the input
    a_stall_blocks_input : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready
    ) else $error("input taken while pipeline is full");

    // refused accesses and reset requests always return a zero word
    a_zero_data_on_flags : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_serr_reg || out_rst_reg)) |-> (out_data_reg == '0)
    ) else $error("nonzero read data with error or reset request");

    // a refused access never raises a reset request
    a_rst_excludes_serr : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_serr_reg && out_rst_reg)
    ) else $error("reset request on a refused access");

    // an accepted access reaches stage 1 on the next edge
    a_accept_fills_s1 : assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg
    ) else $error("accepted access lost before stage 1");

endmodule

[rtl/core/cmrf_store.sv]
module cmrf_store #(
    parameter int REG_WORDS = 2048,
    localparam int IDX_W = $clog2(REG_WORDS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmrf_pkg::store_cmd_t           cmd,
    input  logic [IDX_W-1:0]               idx,
    input  logic [cmrf_pkg::DATA_W-1:0]    wr_data,
    output logic [cmrf_pkg::DATA_W-1:0]    rd_data,
    output logic                           busy
);

    localparam int SEED_IDX_W = cmrf_pkg::STORE_IDX_W;

    logic [cmrf_pkg::DATA_W-1:0] mem [REG_WORDS];

    logic                        busy_reg;
    logic                        busy_next;
    logic [IDX_W-1:0]            clear_idx_reg;
    logic [IDX_W-1:0]            clear_idx_next;
    logic [cmrf_pkg::DATA_W-1:0] rd_data_reg;
    logic [cmrf_pkg::DATA_W-1:0] seed;

    assign seed = cmrf_pkg::seed_word(SEED_IDX_W'(clear_idx_reg));

    // clearing pass: one word per cycle from index 0 up after reset
    always_comb
    begin
        busy_next      = busy_reg;
        clear_idx_next = clear_idx_reg;
        if (busy_reg)
        begin
            if (clear_idx_reg == IDX_W'(REG_WORDS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clear_idx_next = clear_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            clear_idx_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clear_idx_reg] <= seed;
        end
        else if (cmd.wr_en)
        begin
            mem[idx] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
